[rtl/core/swc2d_pkg.sv]
// ============================================================================
// swc2d_pkg: shared definitions for the 2-D sliding window convolution unit
// Kernel geometry, field widths, register codes and the stage structs that
// travel between the line buffer, the window cells and the top level.
// ============================================================================
package swc2d_pkg;

  localparam int KERNEL_SIZE = 3;
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int SAMPLE_BITS = 16;

  localparam int LINE_ROWS = KERNEL_SIZE - 1;
  localparam int HALF      = KERNEL_SIZE / 2;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);

  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int TAP_IDX_W  = 4;
  localparam int VALUE_W    = 16;
  localparam int ACC_W      = 40;
  localparam int PROD_W     = 2 * SAMPLE_BITS;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Input item modes.
  localparam logic MODE_TAP    = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(1024);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(1024);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [KERNEL_SIZE-1:0]     column_t;
  typedef sample_t [LINE_ROWS-1:0]       line_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

  // 1.0 in Q8.8.
  localparam sample_t TAP_ONE = sample_t'(256);

  // Position and flags of the result an item produces.
  typedef struct packed {
    logic             res;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } meta_t;

  // Payload of the stage behind the input port.
  typedef struct packed {
    logic                 is_sample;
    logic [TAP_IDX_W-1:0] tap_idx;
    sample_t              data;
    logic [COL_W-1:0]     addr;
    meta_t                meta;
  } stage_t;

  // One entry of the output queue.
  typedef struct packed {
    acc_t             result;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } out_t;

endpackage

[rtl/core/swc2d_line_buf.sv]
// ============================================================================
// swc2d_line_buf: frame counters and line buffer memory
// Holds the frame size registers and raster counters, reads the stored rows
// for a sample and writes the shifted column back as the sample leaves s1.
// ============================================================================
module swc2d_line_buf (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [swc2d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swc2d_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             take,
  input  logic                             mode,
  input  logic [swc2d_pkg::TAP_IDX_W-1:0]  tap_index,
  input  logic signed [swc2d_pkg::VALUE_W-1:0] value,
  input  logic                             adv,
  output logic                             s1_vld,
  output swc2d_pkg::stage_t                s1,
  output swc2d_pkg::column_t               column
);

  logic [swc2d_pkg::FW_W-1:0]  frame_width;
  logic [swc2d_pkg::FH_W-1:0]  frame_height;
  logic [swc2d_pkg::COL_W-1:0] col;
  logic [swc2d_pkg::ROW_W-1:0] row;
  logic [swc2d_pkg::COL_W-1:0] w_m1;
  logic [swc2d_pkg::ROW_W-1:0] h_m1;
  logic                        take_sample;
  logic                        wb;
  swc2d_pkg::sample_t          smp;
  swc2d_pkg::line_t            rd_data;
  swc2d_pkg::line_t            mem [swc2d_pkg::MAX_WIDTH];

  // Clamp the frame size into the supported range.
  always_comb begin
    if (frame_width < swc2d_pkg::FW_W'(swc2d_pkg::KERNEL_SIZE)) begin
      w_m1 = swc2d_pkg::COL_W'(swc2d_pkg::KERNEL_SIZE - 1);
    end else if (frame_width > swc2d_pkg::FW_W'(swc2d_pkg::MAX_WIDTH)) begin
      w_m1 = swc2d_pkg::COL_W'(swc2d_pkg::MAX_WIDTH - 1);
    end else begin
      w_m1 = swc2d_pkg::COL_W'(frame_width - swc2d_pkg::FW_W'(1));
    end
    if (frame_height < swc2d_pkg::FH_W'(swc2d_pkg::KERNEL_SIZE)) begin
      h_m1 = swc2d_pkg::ROW_W'(swc2d_pkg::KERNEL_SIZE - 1);
    end else if (frame_height > swc2d_pkg::FH_W'(swc2d_pkg::MAX_HEIGHT)) begin
      h_m1 = swc2d_pkg::ROW_W'(swc2d_pkg::MAX_HEIGHT - 1);
    end else begin
      h_m1 = swc2d_pkg::ROW_W'(frame_height - swc2d_pkg::FH_W'(1));
    end
  end

  assign take_sample = take && (mode == swc2d_pkg::MODE_SAMPLE);
  assign smp         = value[swc2d_pkg::SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= swc2d_pkg::FW_RESET;
      frame_height <= swc2d_pkg::FH_RESET;
      col          <= '0;
      row          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swc2d_pkg::REG_FRAME_WIDTH: begin
          frame_width <= cfg_data[swc2d_pkg::FW_W-1:0];
        end
        swc2d_pkg::REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data[swc2d_pkg::FH_W-1:0];
        end
      endcase
      col <= '0;
      row <= '0;
    end else if (take_sample) begin
      if (col == w_m1) begin
        col <= '0;
        row <= (row == h_m1) ? '0 : row + swc2d_pkg::ROW_W'(1);
      end else begin
        col <= col + swc2d_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1.is_sample <= take_sample;
      s1.tap_idx   <= tap_index;
      s1.data      <= smp;
      s1.addr      <= col;
      s1.meta.res  <= take_sample
                      && (row >= swc2d_pkg::ROW_W'(swc2d_pkg::KERNEL_SIZE - 1))
                      && (col >= swc2d_pkg::COL_W'(swc2d_pkg::KERNEL_SIZE - 1));
      s1.meta.last <= (row == h_m1) && (col == w_m1);
      s1.meta.row  <= row - swc2d_pkg::ROW_W'(swc2d_pkg::HALF);
      s1.meta.col  <= col - swc2d_pkg::COL_W'(swc2d_pkg::HALF);
    end
  end

  // The new window column: stored rows oldest first, the sample on top.
  assign column = {s1.data, rd_data};
  assign wb     = adv && s1_vld && s1.is_sample;

  always_ff @(posedge clk) begin
    if (take_sample) begin
      rd_data <= mem[col];
    end
    if (wb) begin
      mem[s1.addr] <= column[swc2d_pkg::KERNEL_SIZE-1:1];
    end
  end

  a_col_range: assert property (@(posedge clk) disable iff (rst) col <= w_m1)
    else $error("column counter beyond frame width");
  a_row_range: assert property (@(posedge clk) disable iff (rst) row <= h_m1)
    else $error("row counter beyond frame height");

endmodule

[rtl/core/swc2d_cell.sv]
// ============================================================================
// swc2d_cell: one column of the convolution window
// Holds a window column and its kernel taps, passes the column to its left
// neighbor on each shift and forms the registered weighted column sum.
// ============================================================================
module swc2d_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic                               shift,
  input  swc2d_pkg::column_t                 col_in,
  output swc2d_pkg::column_t                 col_out,
  input  logic [swc2d_pkg::KERNEL_SIZE-1:0]  tap_wr,
  input  swc2d_pkg::sample_t                 tap_data,
  output swc2d_pkg::acc_t                    sum
);

  swc2d_pkg::column_t col_q;
  swc2d_pkg::column_t taps;
  swc2d_pkg::prod_t   prod [swc2d_pkg::KERNEL_SIZE];
  swc2d_pkg::acc_t    sum_next;

  always_ff @(posedge clk) begin
    if (shift) begin
      col_q <= col_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < swc2d_pkg::KERNEL_SIZE; i++) begin
        taps[i] <= swc2d_pkg::TAP_ONE;
      end
    end else begin
      for (int i = 0; i < swc2d_pkg::KERNEL_SIZE; i++) begin
        if (tap_wr[i]) begin
          taps[i] <= tap_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < swc2d_pkg::KERNEL_SIZE; i++) begin
        prod[i] <= col_q[i] * taps[i];
      end
    end
  end

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < swc2d_pkg::KERNEL_SIZE; i++) begin
      sum_next = sum_next + swc2d_pkg::ACC_W'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum <= sum_next;
    end
  end

  assign col_out = col_q;

endmodule

[rtl/core/sliding_window_convolution_2d_unit.sv]
// ============================================================================
// sliding_window_convolution_2d_unit: streaming 3x3 convolution, line buffered
// Takes signed Q8.8 samples in raster order and returns the Q24.16 weighted
// window sum for each center position whose window lies inside the frame.
// ============================================================================
//
// Channel  Direction  Handshake            Payload
// -------  ---------  -------------------  ---------------------------------
// in       input      in_valid / in_stall  mode, tap_index, value
// out      output     out_valid/out_stall  result, out_row, out_col, last
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One input transaction is taken per cycle while in_stall is low. A result
// is presented after its sample passes the window column register, the
// product register, the column sum register and the output queue, while
// the line buffer read happens at the edge that accepts the sample.
// Reset is synchronous; it restores a 1024 x 1024 frame, all taps at 1.0 and
// empty pipeline and output queue. The line buffer needs no clearing pass.
// A two-entry output queue absorbs out_stall; in_stall rises only while that
// queue is full, and then the whole pipeline holds in place.
//
module sliding_window_convolution_2d_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input stream.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 mode,
  input  logic [swc2d_pkg::TAP_IDX_W-1:0]      tap_index,
  input  logic signed [swc2d_pkg::VALUE_W-1:0] value,
  // Result stream.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [swc2d_pkg::ACC_W-1:0]   result,
  output logic [swc2d_pkg::ROW_W-1:0]          out_row,
  output logic [swc2d_pkg::COL_W-1:0]          out_col,
  output logic                                 last,
  // Configuration writes.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [swc2d_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swc2d_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int K = swc2d_pkg::KERNEL_SIZE;

  logic                 adv;
  logic                 take;
  logic                 cfg_we;
  logic                 s1_vld;
  swc2d_pkg::stage_t    s1;
  swc2d_pkg::column_t   new_col;
  logic                 shift;
  logic                 tap_item;
  swc2d_pkg::column_t   cell_col [K];
  logic [K-1:0]         tap_wr [K];
  swc2d_pkg::acc_t      cell_sum [K];
  swc2d_pkg::acc_t      total;

  logic                 s2_res, s3_res, s4_res;
  swc2d_pkg::meta_t     s2_meta, s3_meta, s4_meta;

  logic [1:0]           cnt;
  swc2d_pkg::out_t      q0, q1;
  swc2d_pkg::out_t      q_in;
  logic                 push;
  logic                 pop;

  // The pipeline moves as a whole whenever the output queue has room. The
  // queue holds two entries, so a result already in flight always finds a
  // slot even when the consumer stalls on the cycle it lands.
  assign adv       = (cnt != 2'd2);
  assign in_stall  = !adv;
  assign take      = in_valid && adv;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  swc2d_line_buf u_line_buf (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .mode      (mode),
    .tap_index (tap_index),
    .value     (value),
    .adv       (adv),
    .s1_vld    (s1_vld),
    .s1        (s1),
    .column    (new_col)
  );

  // A sample shifts the window by one column as it leaves the first stage; a
  // tap write lands in the matching cell at the same point, so both keep the
  // order of the input transactions.
  assign shift    = adv && s1_vld && s1.is_sample;
  assign tap_item = adv && s1_vld && !s1.is_sample;

  // Cell K-1 takes the freshly read column, every other cell takes the
  // column its right neighbor held, which slides the window left.
  for (genvar j = 0; j < K; j++) begin : g_cell
    for (genvar i = 0; i < K; i++) begin : g_tap
      assign tap_wr[j][i] = tap_item && (int'(s1.tap_idx) == i * K + j);
    end

    if (j == K - 1) begin : g_head
      swc2d_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .adv      (adv),
        .shift    (shift),
        .col_in   (new_col),
        .col_out  (cell_col[j]),
        .tap_wr   (tap_wr[j]),
        .tap_data (s1.data),
        .sum      (cell_sum[j])
      );
    end else begin : g_body
      swc2d_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .adv      (adv),
        .shift    (shift),
        .col_in   (cell_col[j+1]),
        .col_out  (cell_col[j]),
        .tap_wr   (tap_wr[j]),
        .tap_data (s1.data),
        .sum      (cell_sum[j])
      );
    end
  end

  // Position and flags follow the data: window update, products, column sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_res <= 1'b0;
      s3_res <= 1'b0;
      s4_res <= 1'b0;
    end else if (adv) begin
      s2_res <= s1_vld && s1.is_sample && s1.meta.res;
      s3_res <= s2_res;
      s4_res <= s3_res;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_meta <= s1.meta;
      s3_meta <= s2_meta;
      s4_meta <= s3_meta;
    end
  end

  // Final sum over the column sums of all cells; the 40-bit width covers
  // the worst case for kernels up to 22x22, larger kernels can wrap.
  always_comb begin
    total = '0;
    for (int j = 0; j < K; j++) begin
      total = total + cell_sum[j];
    end
  end

  assign q_in.result = total;
  assign q_in.last   = s4_meta.last;
  assign q_in.row    = s4_meta.row;
  assign q_in.col    = s4_meta.col;

  assign push = adv && s4_res;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  // The head entry drives the ports; the second entry is the skid slot.
  always_ff @(posedge clk) begin
    priority if (push && ((cnt == 2'd0) || ((cnt == 2'd1) && pop))) begin
      q0 <= q_in;
    end else if (pop) begin
      q0 <= q1;
    end else begin
      q0 <= q0;
    end
    if (push && (((cnt == 2'd1) && !pop) || ((cnt == 2'd2) && pop))) begin
      q1 <= q_in;
    end
  end

  assign out_valid = (cnt != 2'd0);
  assign result    = q0.result;
  assign out_row   = q0.row;
  assign out_col   = q0.col;
  assign last      = q0.last;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (cnt != 2'd2))
    else $error("result pushed into a full output queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output queue count out of range");
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid)
    else $error("pushed result not presented on the output");

endmodule
